### rtl/lfla_pkg.sv
// shared types and codes for the linked free-list block allocator
// no dependencies; used by the top level and its checker
`default_nettype none

package lfla_pkg;

  localparam int unsigned BLK_W   = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_START = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_REFUSED  = 2'd2,
    STAT_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HEAD = 1'b0,
    REG_RESERVED   = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_EXEC    = 6'b000010,
    ST_ALLOC_RD = 6'b000100,
    ST_WALK    = 6'b001000,
    ST_STEP    = 6'b010000,
    ST_RESULT  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

### rtl/linked_free_list_block_allocator_top.sv
// linked free-list block allocator: link table memory, head pointer, free count
// and a small sequencer around one shared count adder; uses lfla_pkg
`default_nettype none

// channel     dir  handshake                 payload
// s_axis      in   s_axis_tvalid/tready      tuser: mode; tdata: block_index, link_value
// m_axis      out  m_axis_tvalid/tready      tuser: status; tdata: granted_block, free_total
// cfg         in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i (always ready)
//
// load and free pass from accept through EXEC and RESULT to the output register, allocate
// of an in-range head adds ALLOC_RD (one registered read of the link table), start loops
// WALK and STEP per link walked, up to min(NUM_BLOCKS, 4096) links: each step is one read of the single table port
// input is ready again as soon as the result is loaded into the output register, even while that result waits
// rst_ni clears head, count, config and the sequencer; the link table has no reset
// a stalled output holds the sequencer in its result state until the slot frees

module linked_free_list_block_allocator_top #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [11:0] block_index, [23:12] link_value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [11:0] granted_block, [24:12] free_total
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [lfla_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  // only the first 4096 entries can be named by a 12-bit block number
  localparam int unsigned MEM_DEPTH = (NUM_BLOCKS < 4096) ? NUM_BLOCKS : 4096;
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  // table size doubles as the walk limit
  localparam logic [lfla_pkg::CNT_W-1:0] DEPTH_C = lfla_pkg::CNT_W'(MEM_DEPTH);

  localparam int unsigned BW = lfla_pkg::BLK_W;
  localparam int unsigned CW = lfla_pkg::CNT_W;

  // state and registers
  lfla_pkg::state_e  state_q, state_d;
  lfla_pkg::mode_e   op_mode_q;
  logic [BW-1:0]     op_blk_q, op_link_q;
  logic [BW-1:0]     head_q, head_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [BW-1:0]     walk_q, walk_d;
  logic [BW-1:0]     res_granted_q, res_granted_d;
  lfla_pkg::status_e res_status_q, res_status_d;
  logic [BW-1:0]     start_head_q, reserved_q;

  logic              out_valid_q;
  logic [BW-1:0]     out_granted_q;
  logic [CW-1:0]     out_total_q;
  lfla_pkg::status_e out_status_q;

  // link table port
  logic [BW-1:0]     mem [MEM_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [BW-1:0]     mem_wdata;
  logic [BW-1:0]     mem_rdata_q;

  // shared count adder: +1 for free and walk steps, -1 for allocate
  logic [CW-1:0]     cnt_delta;
  logic [CW-1:0]     cnt_sum;

  logic              s_accept;
  logic              out_free;
  logic              finish;
  logic              blk_in_range;
  logic              head_in_range;
  logic              walk_in_range;

  assign s_axis_tready = (state_q == lfla_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign out_free = !out_valid_q || m_axis_tready;
  assign finish   = (state_q == lfla_pkg::ST_RESULT) && out_free;

  assign blk_in_range  = {1'b0, op_blk_q} < DEPTH_C;
  assign head_in_range = {1'b0, head_q} < DEPTH_C;
  assign walk_in_range = {1'b0, walk_q} < DEPTH_C;

  assign cnt_delta = ((state_q == lfla_pkg::ST_EXEC) && (op_mode_q == lfla_pkg::MODE_ALLOC))
                     ? {CW{1'b1}} : CW'(1);
  assign cnt_sum   = cnt_q + cnt_delta;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q <= '0;
      reserved_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lfla_pkg::REG_START_HEAD: start_head_q <= cfg_data_i;
        lfla_pkg::REG_RESERVED:   reserved_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latch the accepted item
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_mode_q <= lfla_pkg::mode_e'(s_axis_tuser);
      op_blk_q  <= s_axis_tdata[11:0];
      op_link_q <= s_axis_tdata[23:12];
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    cnt_d         = cnt_q;
    walk_d        = walk_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    mem_we        = 1'b0;
    mem_addr      = op_blk_q[AW-1:0];
    mem_wdata     = op_link_q;

    case (state_q)
      lfla_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_d = lfla_pkg::ST_EXEC;
        end
      end

      lfla_pkg::ST_EXEC: begin
        res_granted_d = '0;
        res_status_d  = lfla_pkg::STAT_OK;
        state_d       = lfla_pkg::ST_RESULT;
        case (op_mode_q)
          lfla_pkg::MODE_LOAD: begin
            // out-of-range loads are dropped silently
            mem_we = blk_in_range;
          end
          lfla_pkg::MODE_ALLOC: begin
            if (head_q == '0) begin
              res_status_d = lfla_pkg::STAT_EMPTY;
            end else begin
              res_granted_d = head_q;
              if (cnt_q != '0) begin
                cnt_d = cnt_sum;
              end
              mem_addr = head_q[AW-1:0];
              if (head_in_range) begin
                state_d = lfla_pkg::ST_ALLOC_RD;
              end else begin
                head_d = '0;
              end
            end
          end
          lfla_pkg::MODE_FREE: begin
            if ((op_blk_q <= reserved_q) || !blk_in_range) begin
              res_status_d = lfla_pkg::STAT_REFUSED;
            end else begin
              // push: new block points at the old head
              mem_we    = 1'b1;
              mem_wdata = head_q;
              head_d    = op_blk_q;
              if (cnt_q != lfla_pkg::COUNT_MAX) begin
                cnt_d = cnt_sum;
              end
            end
          end
          lfla_pkg::MODE_START: begin
            head_d  = start_head_q;
            walk_d  = start_head_q;
            cnt_d   = '0;
            state_d = lfla_pkg::ST_WALK;
          end
          default: ;
        endcase
      end

      lfla_pkg::ST_ALLOC_RD: begin
        head_d  = mem_rdata_q;
        state_d = lfla_pkg::ST_RESULT;
      end

      lfla_pkg::ST_WALK: begin
        mem_addr = walk_q[AW-1:0];
        if (walk_q == '0) begin
          state_d = lfla_pkg::ST_RESULT;
        end else if (cnt_q == DEPTH_C) begin
          // walk limit hit without reaching the end: list loops
          res_status_d = lfla_pkg::STAT_TOO_LONG;
          state_d      = lfla_pkg::ST_RESULT;
        end else begin
          cnt_d = cnt_sum;
          if (walk_in_range) begin
            state_d = lfla_pkg::ST_STEP;
          end else begin
            walk_d = '0;
          end
        end
      end

      lfla_pkg::ST_STEP: begin
        walk_d  = mem_rdata_q;
        state_d = lfla_pkg::ST_WALK;
      end

      lfla_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = lfla_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lfla_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfla_pkg::ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      walk_q  <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_granted_q <= res_granted_d;
    res_status_q  <= res_status_d;
  end

  // link table, single port with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_granted_q <= res_granted_q;
      out_total_q   <= cnt_q;
      out_status_q  <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_total_q, out_granted_q};
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

### rtl/lfla_checker.sv
// port-level checks for the linked free-list block allocator
// uses lfla_pkg; bound to linked_free_list_block_allocator_top below
`default_nettype none

module lfla_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a block is only granted with an ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != lfla_pkg::STAT_OK) |-> m_axis_tdata[11:0] == 12'd0)
    else $error("block granted with error status");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");

  // unused upper data bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0)
    else $error("padding bits set");

endmodule

bind linked_free_list_block_allocator_top lfla_checker u_lfla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### bench/tb_top.sv
// self-checking bench for the linked free-list block allocator top level
// needs lfla_pkg and linked_free_list_block_allocator_top; drives both streams and the
// register channel, predicts each result item in-bench or takes it from the directed row, and checks it at the output
`default_nettype none

module tb_top;

  localparam int unsigned BLK_W       = lfla_pkg::BLK_W;
  localparam int unsigned CNT_W       = lfla_pkg::CNT_W;
  localparam int unsigned CFG_IDX_W   = lfla_pkg::CFG_IDX_W;
  localparam int unsigned TABLE_DEPTH = 4096;
  // start walk follows at most min(NUM_BLOCKS, 4096) links
  localparam int unsigned WALK_MAX    = 4096;
  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam int unsigned HOLD_CYCLES = 300;
  // total links the random starts may walk, keeps loop walks to a handful
  localparam int          WALK_BUDGET = 60000;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // one result item as it leaves the block
  typedef struct {
    logic [BLK_W-1:0] granted;
    logic [CNT_W-1:0] total;
    logic [1:0]       status;
  } alloc_result_t;

  // one row of the directed part: either a register write or an item
  typedef struct {
    bit                 is_cfg;
    lfla_pkg::cfg_reg_e reg_sel;
    logic [BLK_W-1:0]   cfg_val;
    lfla_pkg::mode_e    mode;
    logic [BLK_W-1:0]   blk;
    logic [BLK_W-1:0]   link;
    bit                 typed;
    alloc_result_t      want;
  } dir_row_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // block ports, all inputs known from time zero
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [11:0] block_index, [23:12] link_value
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [11:0] granted_block, [24:12] free_total
  logic [1:0]  m_axis_tuser;         // [1:0] status
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [11:0] cfg_data_i    = '0;

  linked_free_list_block_allocator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // bench copy of the allocator state and its registers
  logic [BLK_W-1:0] link_mem   [TABLE_DEPTH];
  bit               link_known [TABLE_DEPTH];   // entry loaded or written by a free
  logic [BLK_W-1:0] head_blk       = '0;
  logic [CNT_W-1:0] free_cnt       = '0;
  logic [BLK_W-1:0] cfg_start_head = '0;
  logic [BLK_W-1:0] cfg_reserved   = '0;

  // results the block still owes, oldest first
  alloc_result_t awaited_results[$];

  int  fail_count  = 0;
  bit  rx_idle_on  = 1'b1;
  bit  tx_idle_on  = 1'b1;
  int  hold_asked  = 0;

  // follow the list from first; stops at block 0, at the walk limit, or at an entry
  // that was never written (which the stimulus must steer around)
  function automatic void walk_from(input logic [BLK_W-1:0] first, output int steps,
                                    output logic [BLK_W-1:0] stop, output bit hit_unknown);
    logic [BLK_W-1:0] cur;
    cur         = first;
    steps       = 0;
    hit_unknown = 1'b0;
    while (cur != 0 && steps < WALK_MAX) begin
      if (!link_known[cur]) begin
        hit_unknown = 1'b1;
        break;
      end
      steps++;
      cur = link_mem[cur];
    end
    stop = cur;
  endfunction

  // advance the bench state by one accepted item and return its result
  function automatic alloc_result_t next_allocator_result(lfla_pkg::mode_e m,
                                                          logic [BLK_W-1:0] blk,
                                                          logic [BLK_W-1:0] link);
    alloc_result_t    r;
    int               steps;
    logic [BLK_W-1:0] stop;
    bit               hit;
    r.granted = '0;
    r.status  = lfla_pkg::STAT_OK;
    case (m)
      lfla_pkg::MODE_LOAD: begin
        link_mem[blk]   = link;
        link_known[blk] = 1'b1;
      end
      lfla_pkg::MODE_ALLOC: begin
        if (head_blk == 0) begin
          r.status = lfla_pkg::STAT_EMPTY;
        end else begin
          r.granted = head_blk;
          head_blk  = link_mem[head_blk];
          if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
        end
      end
      lfla_pkg::MODE_FREE: begin
        // block 0 is always at or below the reserved count
        if (blk <= cfg_reserved) begin
          r.status = lfla_pkg::STAT_REFUSED;
        end else begin
          link_mem[blk]   = head_blk;
          link_known[blk] = 1'b1;
          head_blk        = blk;
          if (free_cnt != lfla_pkg::COUNT_MAX) free_cnt = free_cnt + 1'b1;
        end
      end
      default: begin
        walk_from(cfg_start_head, steps, stop, hit);
        head_blk = cfg_start_head;
        free_cnt = CNT_W'(steps);
        // list not ended after the walk limit: a loop
        if (stop != 0) r.status = lfla_pkg::STAT_TOO_LONG;
      end
    endcase
    r.total = free_cnt;
    return r;
  endfunction

  function automatic dir_row_t item_row(lfla_pkg::mode_e m, logic [BLK_W-1:0] blk,
                                        logic [BLK_W-1:0] link);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_sel = lfla_pkg::REG_START_HEAD;
    row.cfg_val = '0;
    row.mode    = m;
    row.blk     = blk;
    row.link    = link;
    row.typed   = 1'b0;
    row.want    = '{default: '0};
    return row;
  endfunction

  function automatic dir_row_t item_row_known(lfla_pkg::mode_e m, logic [BLK_W-1:0] blk,
                                              logic [BLK_W-1:0] link, logic [BLK_W-1:0] g,
                                              logic [CNT_W-1:0] t, lfla_pkg::status_e st);
    dir_row_t row;
    row              = item_row(m, blk, link);
    row.typed        = 1'b1;
    row.want.granted = g;
    row.want.total   = t;
    row.want.status  = st;
    return row;
  endfunction

  function automatic dir_row_t reg_row(lfla_pkg::cfg_reg_e r, logic [BLK_W-1:0] v);
    dir_row_t row;
    row         = item_row(lfla_pkg::MODE_LOAD, '0, '0);
    row.is_cfg  = 1'b1;
    row.reg_sel = r;
    row.cfg_val = v;
    return row;
  endfunction

  // sender idles with valid low, data lines carry noise meanwhile
  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);
      s_axis_tuser  <= 2'($urandom);
    end
  endtask

  // offer one item and book its expected result once it is taken;
  // valid stays high afterwards, the next action of the sender decides
  task automatic offer_item(lfla_pkg::mode_e m, logic [BLK_W-1:0] blk,
                            logic [BLK_W-1:0] link, bit typed, alloc_result_t want);
    alloc_result_t got;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {link, blk};
    s_axis_tuser  <= m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = next_allocator_result(m, blk, link);
    awaited_results.push_back(typed ? want : got);
  endtask

  // stop sending and wait for every owed result
  task automatic drain_results();
    pause_sender(1);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic set_register(lfla_pkg::cfg_reg_e r, logic [BLK_W-1:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (r == lfla_pkg::REG_START_HEAD) cfg_start_head = v;
    else cfg_reserved = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stall bursts, and one long hold-off when asked
  initial begin : result_sink
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_seen) begin
        hold_seen  = hold_asked;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each taken result item with the oldest expectation
  always @(posedge clk_i) begin : check_results
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result item: granted %0d total %0d status %0d",
                   m_axis_tdata[11:0], m_axis_tdata[24:12], m_axis_tuser);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata[11:0] !== want.granted || m_axis_tdata[24:12] !== want.total ||
            m_axis_tuser !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected granted %0d total %0d status %0d, got %0d %0d %0d",
                     want.granted, want.total, want.status,
                     m_axis_tdata[11:0], m_axis_tdata[24:12], m_axis_tuser);
        end
      end
    end
  end

  // hang guard
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    dir_row_t         rows[$];
    alloc_result_t    no_want;
    lfla_pkg::mode_e  m;
    logic [BLK_W-1:0] b, l, sh, rsv, pool_lo, stop;
    int               pick, steps, walk_budget;
    bit               hit;

    no_want     = '{default: '0};
    walk_budget = WALK_BUDGET;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, registers at reset: start head 0, reserved count 0
    rows.push_back(item_row_known(lfla_pkg::MODE_ALLOC, 12'd0, 12'd0, 12'd0, 13'd0,
                                  lfla_pkg::STAT_EMPTY));
    // block 0 is never freed
    rows.push_back(item_row_known(lfla_pkg::MODE_FREE, 12'd0, 12'd0, 12'd0, 13'd0,
                                  lfla_pkg::STAT_REFUSED));
    rows.push_back(item_row_known(lfla_pkg::MODE_START, 12'd0, 12'd0, 12'd0, 13'd0,
                                  lfla_pkg::STAT_OK));
    rows.push_back(item_row_known(lfla_pkg::MODE_FREE, 12'd4095, 12'd4095, 12'd0, 13'd1,
                                  lfla_pkg::STAT_OK));
    rows.push_back(item_row_known(lfla_pkg::MODE_FREE, 12'd1, 12'd0, 12'd0, 13'd2,
                                  lfla_pkg::STAT_OK));
    rows.push_back(item_row_known(lfla_pkg::MODE_ALLOC, 12'd0, 12'd0, 12'd1, 13'd1,
                                  lfla_pkg::STAT_OK));
    rows.push_back(item_row_known(lfla_pkg::MODE_ALLOC, 12'd0, 12'd0, 12'd4095, 13'd0,
                                  lfla_pkg::STAT_OK));
    rows.push_back(item_row_known(lfla_pkg::MODE_ALLOC, 12'd0, 12'd0, 12'd0, 13'd0,
                                  lfla_pkg::STAT_EMPTY));
    rows.push_back(item_row_known(lfla_pkg::MODE_LOAD, 12'd0, 12'd4095, 12'd0, 13'd0,
                                  lfla_pkg::STAT_OK));
    // self loop on the top block
    rows.push_back(item_row_known(lfla_pkg::MODE_LOAD, 12'd4095, 12'd4095, 12'd0, 13'd0,
                                  lfla_pkg::STAT_OK));
    rows.push_back(reg_row(lfla_pkg::REG_START_HEAD, 12'd4095));
    // walk runs out of links: loop flagged, count is the full walk
    rows.push_back(item_row_known(lfla_pkg::MODE_START, 12'd0, 12'd0, 12'd0, 13'd4096,
                                  lfla_pkg::STAT_TOO_LONG));
    rows.push_back(item_row_known(lfla_pkg::MODE_ALLOC, 12'd0, 12'd0, 12'd4095, 13'd4095,
                                  lfla_pkg::STAT_OK));
    rows.push_back(item_row(lfla_pkg::MODE_LOAD, 12'd5, 12'd6));
    rows.push_back(item_row(lfla_pkg::MODE_LOAD, 12'd6, 12'd0));
    rows.push_back(reg_row(lfla_pkg::REG_START_HEAD, 12'd5));
    rows.push_back(item_row(lfla_pkg::MODE_START, 12'd0, 12'd0));
    // close 5 -> 6 -> 5, then pop past the count so it sticks at zero
    rows.push_back(item_row(lfla_pkg::MODE_LOAD, 12'd6, 12'd5));
    rows.push_back(item_row(lfla_pkg::MODE_ALLOC, 12'd0, 12'd0));
    rows.push_back(item_row(lfla_pkg::MODE_ALLOC, 12'd0, 12'd0));
    rows.push_back(item_row(lfla_pkg::MODE_ALLOC, 12'd0, 12'd0));
    rows.push_back(reg_row(lfla_pkg::REG_RESERVED, 12'd4095));
    rows.push_back(item_row_known(lfla_pkg::MODE_FREE, 12'd4095, 12'd0, 12'd0, 13'd0,
                                  lfla_pkg::STAT_REFUSED));
    rows.push_back(item_row(lfla_pkg::MODE_FREE, 12'd2048, 12'd0));
    rows.push_back(reg_row(lfla_pkg::REG_RESERVED, 12'd0));
    rows.push_back(item_row(lfla_pkg::MODE_FREE, 12'd2, 12'd0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        set_register(rows[i].reg_sel, rows[i].cfg_val);
      end else begin
        if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 16));
        offer_item(rows[i].mode, rows[i].blk, rows[i].link, rows[i].typed, rows[i].want);
      end
    end

    // random part: one register setting per phase, items mostly on a small block pool
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin rsv = 12'd0;    sh = 12'd0;    end
        1: begin rsv = 12'd4095; sh = 12'd4095; end
        2: begin rsv = 12'($urandom_range(0, 15)); sh = rsv + 12'($urandom_range(1, 48)); end
        3: begin rsv = 12'($urandom); sh = 12'($urandom); end
        4: begin rsv = 12'd0; sh = 12'($urandom_range(1, 47)); end
        default: begin
          rsv = 12'($urandom_range(0, 63));
          sh  = rsv + 12'($urandom_range(1, 48));
        end
      endcase
      set_register(lfla_pkg::REG_RESERVED, rsv);
      set_register(lfla_pkg::REG_START_HEAD, sh);
      // one stretch in the middle and the whole tail run without idling
      tx_idle_on = (p != 3) && (p != N_PHASES - 1);
      rx_idle_on = tx_idle_on;
      pool_lo = (cfg_reserved < 12'd4040) ? cfg_reserved + 1'b1 : 12'd4040;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while items keep coming: fills the block
        if (p == 2 && n == 10) hold_asked++;
        // sender waits until all results are back, mid phase
        if (p == 4 && n == 70) drain_results();
        if (tx_idle_on && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 16));

        pick = $urandom_range(0, 9);
        l = (pick < 4) ? 12'd0 :
            (pick < 8) ? pool_lo + 12'($urandom_range(0, 47)) : 12'($urandom);
        pick = $urandom_range(0, 9);
        b = (pick < 6) ? pool_lo + 12'($urandom_range(0, 47)) :
            (pick < 8) ? 12'($urandom) : 12'($urandom_range(0, cfg_reserved));

        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          m = lfla_pkg::MODE_FREE;
        end else if (pick < 70) begin
          m = lfla_pkg::MODE_ALLOC;
        end else if (pick < 92) begin
          m = lfla_pkg::MODE_LOAD;
          if ($urandom_range(0, 3) == 0 && cfg_start_head != 0) b = cfg_start_head;
        end else begin
          m = lfla_pkg::MODE_START;
        end

        // never let the block read an entry that was never written:
        // load the missing entry instead, and cap the total walking
        if (m == lfla_pkg::MODE_START) begin
          walk_from(cfg_start_head, steps, stop, hit);
          if (hit) begin
            m = lfla_pkg::MODE_LOAD;
            b = stop;
          end else if (steps > walk_budget) begin
            m = lfla_pkg::MODE_ALLOC;
          end else begin
            walk_budget -= steps;
          end
        end
        if (m == lfla_pkg::MODE_ALLOC && head_blk != 0 && !link_known[head_blk]) begin
          m = lfla_pkg::MODE_LOAD;
          b = head_blk;
        end

        offer_item(m, b, l, 1'b0, no_want);
      end
    end

    drain_results();
    // let any stray result item show before the verdict
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
